// ----- sv/timestamp_ordered_queue_top_defines.svh -----
// Assertion macros shared by the timestamp ordered queue RTL.
`ifndef TIMESTAMP_ORDERED_QUEUE_TOP_DEFINES_SVH
`define TIMESTAMP_ORDERED_QUEUE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- sv/tsq_pkg.sv -----
// Shared constants, operation codes and control types of the timestamp ordered queue.
`default_nettype none
package tsq_pkg;

  localparam int KIND_W         = 2;
  localparam int TAG_W          = 16;
  localparam int STAMP_W        = 48;
  localparam int DEPTH_DEF      = 16;
  localparam int STAMP_BITS_DEF = 48;

  // Operation codes carried in the kind field
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TAKE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the request payload
    logic exec;     // run the latched request and load the result register
  } tsq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_full;  // result register holds a transfer not yet taken
  } tsq_sts_t;

endpackage
`default_nettype wire

// ----- sv/tsq_if.sv -----
// Request and result channel interfaces of the timestamp ordered queue.
`default_nettype none
interface tsq_in_if import tsq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [TAG_W-1:0]   msg_tag;
  logic [STAMP_W-1:0] msg_stamp;
  logic [STAMP_W-1:0] now_time;

  modport source (output valid, kind, msg_tag, msg_stamp, now_time, input ready);
  modport sink   (input valid, kind, msg_tag, msg_stamp, now_time, output ready);
endinterface

interface tsq_out_if import tsq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TAG_W-1:0]   out_tag;
  logic               gave;
  logic               more_ready;
  logic               found;
  logic [STAMP_W-1:0] head_stamp;
  logic               dropped;

  modport source (output valid, out_tag, gave, more_ready, found, head_stamp, dropped,
                  input ready);
  modport sink   (input valid, out_tag, gave, more_ready, found, head_stamp, dropped,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/tsq_ctrl.sv -----
// Controller state machine: sequences capture and execution of one request at a time.
`default_nettype none
`include "timestamp_ordered_queue_top_defines.svh"
module tsq_ctrl import tsq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     out_ready,
  input  wire tsq_sts_t sts,
  output tsq_cmd_t      cmd
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r;
  logic   out_free;

  // Result register can take a new value this cycle
  assign out_free = !sts.out_full || out_ready;

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state_r == S_EXEC) && out_free;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd.capture) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_accept_in_exec, clk, rst_n, state_r == S_EXEC, !in_ready)
  `ASSERT_NEXT(a_capture_to_exec, clk, rst_n, cmd.capture, state_r == S_EXEC)
  `ASSERT_NEXT(a_exec_to_idle, clk, rst_n, cmd.exec, state_r == S_IDLE && sts.out_full)

endmodule
`default_nettype wire

// ----- sv/tsq_datapath.sv -----
// Datapath: sorted shift cells, entry count, request latch and result register.
`default_nettype none
`include "timestamp_ordered_queue_top_defines.svh"
module tsq_datapath import tsq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tsq_cmd_t           cmd,
  output tsq_sts_t                sts,
  input  wire logic [KIND_W-1:0]  in_kind,
  input  wire logic [TAG_W-1:0]   in_msg_tag,
  input  wire logic [STAMP_W-1:0] in_msg_stamp,
  input  wire logic [STAMP_W-1:0] in_now_time,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [TAG_W-1:0]        out_tag,
  output logic                    out_gave,
  output logic                    out_more_ready,
  output logic                    out_found,
  output logic [STAMP_W-1:0]      out_head_stamp,
  output logic                    out_dropped
);

  // Stored stamp width: the port carries at most STAMP_W bits
  localparam int SW = (STAMP_BITS < STAMP_W) ? STAMP_BITS : STAMP_W;
  localparam int CW = $clog2(DEPTH + 1);

  // Request latch
  logic [KIND_W-1:0] kind_r;
  logic [TAG_W-1:0]  tag_r;
  logic [SW-1:0]     stamp_r;
  logic [SW-1:0]     now_r;

  // Shift cells, head at index 0
  logic [SW-1:0]    stamp_cell_r   [DEPTH];
  logic [SW-1:0]    stamp_cell_nxt [DEPTH];
  logic [TAG_W-1:0] tag_cell_r     [DEPTH];
  logic [TAG_W-1:0] tag_cell_nxt   [DEPTH];
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;

  // Result register
  logic               out_valid_r;
  logic [TAG_W-1:0]   out_tag_r,   out_tag_nxt;
  logic               gave_r,      gave_nxt;
  logic               more_r,      more_nxt;
  logic               found_r,     found_nxt;
  logic [STAMP_W-1:0] head_r,      head_nxt;
  logic               dropped_r,   dropped_nxt;

  logic [DEPTH-1:0] le;
  logic             full;
  logic             head_due;
  logic             next_due;

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      tag_r   <= in_msg_tag;
      stamp_r <= in_msg_stamp[SW-1:0];
      now_r   <= in_now_time[SW-1:0];
    end
  end

  // Per-cell compare: occupied and stamp not above the new one
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      le[k] = (CW'(k) < count_r) && (stamp_cell_r[k] <= stamp_r);
    end
  end

  assign full     = (count_r == CW'(DEPTH));
  assign head_due = (count_r != '0) && (stamp_cell_r[0] <= now_r);
  assign next_due = (count_r > CW'(1)) && (stamp_cell_r[1] <= now_r);

  // Next cell contents and result
  always_comb begin
    stamp_cell_nxt = stamp_cell_r;
    tag_cell_nxt   = tag_cell_r;
    count_nxt      = count_r;
    out_tag_nxt    = '0;
    gave_nxt       = 1'b0;
    more_nxt       = 1'b0;
    found_nxt      = 1'b0;
    head_nxt       = '0;
    dropped_nxt    = 1'b0;
    if (cmd.exec) begin
      case (kind_r)
        KIND_INSERT: begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            // Cells past the insertion point shift back by one
            if (!le[0]) begin
              stamp_cell_nxt[0] = stamp_r;
              tag_cell_nxt[0]   = tag_r;
            end
            for (int k = 1; k < DEPTH; k++) begin
              if (!le[k]) begin
                if (le[k-1]) begin
                  stamp_cell_nxt[k] = stamp_r;
                  tag_cell_nxt[k]   = tag_r;
                end else begin
                  stamp_cell_nxt[k] = stamp_cell_r[k-1];
                  tag_cell_nxt[k]   = tag_cell_r[k-1];
                end
              end
            end
            count_nxt = count_r + 1'b1;
          end
        end
        KIND_TAKE: begin
          if (head_due) begin
            out_tag_nxt = tag_cell_r[0];
            gave_nxt    = 1'b1;
            more_nxt    = next_due;
            for (int k = 0; k < DEPTH - 1; k++) begin
              stamp_cell_nxt[k] = stamp_cell_r[k+1];
              tag_cell_nxt[k]   = tag_cell_r[k+1];
            end
            count_nxt = count_r - 1'b1;
          end
        end
        KIND_PEEK: begin
          if (count_r != '0) begin
            found_nxt = 1'b1;
            head_nxt  = STAMP_W'(stamp_cell_r[0]);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Cell storage, not reset; only an executed insert or take changes it
  always_ff @(posedge clk) begin
    stamp_cell_r <= stamp_cell_nxt;
    tag_cell_r   <= tag_cell_nxt;
  end

  // Entry count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_tag_r <= out_tag_nxt;
      gave_r    <= gave_nxt;
      more_r    <= more_nxt;
      found_r   <= found_nxt;
      head_r    <= head_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign sts.out_full   = out_valid_r;
  assign out_valid      = out_valid_r;
  assign out_tag        = out_tag_r;
  assign out_gave       = gave_r;
  assign out_more_ready = more_r;
  assign out_found      = found_r;
  assign out_head_stamp = head_r;
  assign out_dropped    = dropped_r;

  `ASSERT_IMPL(a_count_in_range, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `ASSERT_NEXT(a_take_pops_one, clk, rst_n, cmd.exec && kind_r == KIND_TAKE && head_due, count_r == $past(count_r) - 1'b1)
  `ASSERT_NEXT(a_full_insert_drops, clk, rst_n, cmd.exec && kind_r == KIND_INSERT && full, $stable(count_r) && out_dropped)

endmodule
`default_nettype wire

// ----- sv/timestamp_ordered_queue_top.sv -----
// Timestamp ordered queue: a stable sorted queue of message tags keyed by timestamp.
//
// Requests arrive on in_ch (valid/ready); a transfer happens at a clock edge with both
// high. kind selects insert (tag and stamp), take (removes the head if its stamp is at
// or before now_time) or peek (earliest stamp). Every request gives exactly one result
// transfer on out_ch; fields that do not belong to the request are zero.
// Entries are held in a row of shift cells, ascending; equal stamps keep arrival order.
// An insert into a full queue is discarded and flagged with dropped.
// A request is captured in S_IDLE and executed in S_EXEC, which loads the result
// register. No new request is taken until the last one has executed.
// The result register decouples the sides: a new request is taken while a result still
// waits, but its execution holds until out_ch.ready frees the register.
// Reset (rst_n low, synchronous) empties the queue and clears the result valid; there
// is no clearing pass, so the queue accepts requests as soon as reset is released.
`default_nettype none
module timestamp_ordered_queue_top import tsq_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  tsq_in_if.sink    in_ch,
  tsq_out_if.source out_ch
);

  tsq_cmd_t cmd;
  tsq_sts_t sts;

  // Handshake sequencing
  tsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Queue storage and result register
  tsq_datapath #(
    .DEPTH      (DEPTH),
    .STAMP_BITS (STAMP_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_ch.kind),
    .in_msg_tag     (in_ch.msg_tag),
    .in_msg_stamp   (in_ch.msg_stamp),
    .in_now_time    (in_ch.now_time),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_tag        (out_ch.out_tag),
    .out_gave       (out_ch.gave),
    .out_more_ready (out_ch.more_ready),
    .out_found      (out_ch.found),
    .out_head_stamp (out_ch.head_stamp),
    .out_dropped    (out_ch.dropped)
  );

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the timestamp ordered queue: random and directed requests.
`timescale 1ns / 1ps
module testbench;
  import tsq_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [TAG_W-1:0]   msg_tag;
    logic [STAMP_W-1:0] msg_stamp;
    logic [STAMP_W-1:0] now_time;
  } req_t;

  typedef struct {
    logic [TAG_W-1:0]   out_tag;
    logic               gave;
    logic               more_ready;
    logic               found;
    logic [STAMP_W-1:0] head_stamp;
    logic               dropped;
  } rsp_t;

  logic clk;
  logic rst_n;

  tsq_in_if  in_ch();
  tsq_out_if out_ch();

  timestamp_ordered_queue_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Requests waiting to be offered, results waiting to arrive
  req_t req_pending[$];
  rsp_t rsp_expected[$];

  // Shadow copy of the sorted queue
  logic [STAMP_W-1:0] sq_stamp[QDEPTH];
  logic [TAG_W-1:0]   sq_tag[QDEPTH];
  int                 sq_count = 0;

  int mismatches = 0;
  int phase_no = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit out_hold = 1'b0;
  logic [STAMP_W-1:0] gen_time = 48'h1_0000;

  req_t drv_req;
  rsp_t drv_rsp;
  rsp_t mon_want;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [STAMP_W-1:0] got,
                                 input logic [STAMP_W-1:0] want);
    if (mismatches < MAX_PRINTS)
      $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Apply one request to the shadow queue and work out its result
  task automatic sorted_queue_step(input req_t r, output rsp_t res);
    int pos;
    res = '{default: '0};
    case (r.kind)
      KIND_INSERT: begin
        if (sq_count >= QDEPTH) begin
          res.dropped = 1'b1;
        end else begin
          pos = 0;
          // stable: goes behind every stamp <= its own
          while (pos < sq_count && sq_stamp[pos] <= r.msg_stamp) pos++;
          for (int k = sq_count; k > pos; k--) begin
            sq_stamp[k] = sq_stamp[k-1];
            sq_tag[k]   = sq_tag[k-1];
          end
          sq_stamp[pos] = r.msg_stamp;
          sq_tag[pos]   = r.msg_tag;
          sq_count++;
        end
      end
      KIND_TAKE: begin
        if (sq_count != 0 && sq_stamp[0] <= r.now_time) begin
          res.out_tag = sq_tag[0];
          res.gave    = 1'b1;
          for (int k = 1; k < sq_count; k++) begin
            sq_stamp[k-1] = sq_stamp[k];
            sq_tag[k-1]   = sq_tag[k];
          end
          sq_count--;
          if (sq_count > 0 && sq_stamp[0] <= r.now_time) res.more_ready = 1'b1;
        end
      end
      KIND_PEEK: begin
        if (sq_count != 0) begin
          res.found      = 1'b1;
          res.head_stamp = sq_stamp[0];
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [STAMP_W-1:0] rand_stamp();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  task automatic add_req(input logic [KIND_W-1:0] kind, input logic [TAG_W-1:0] tag,
                         input logic [STAMP_W-1:0] stamp, input logic [STAMP_W-1:0] now);
    req_t r;
    r.kind      = kind;
    r.msg_tag   = tag;
    r.msg_stamp = stamp;
    r.now_time  = now;
    req_pending.insert(req_pending.size(), r);
  endtask

  // Bursts that mostly fill or mostly drain; stamps cluster near a slowly rising time
  task automatic add_random_reqs(input int n);
    req_t r;
    int burst_left;
    bit filling;
    int pick;
    burst_left = 0;
    filling = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(6, 28);
        filling = 1'($urandom_range(1));
        if ($urandom_range(7) == 0) gen_time = rand_stamp() >> 1;
      end
      burst_left--;
      pick = $urandom_range(99);
      if (filling)
        r.kind = (pick < 70) ? KIND_INSERT : (pick < 88) ? KIND_TAKE :
                 (pick < 98) ? KIND_PEEK : KIND_UNUSED;
      else
        r.kind = (pick < 25) ? KIND_INSERT : (pick < 80) ? KIND_TAKE :
                 (pick < 98) ? KIND_PEEK : KIND_UNUSED;
      r.msg_tag   = 16'($urandom());
      r.msg_stamp = gen_time + (48'($urandom_range(0, 15)) << 16);
      if ($urandom_range(3) == 0) r.msg_stamp += 48'($urandom_range(0, 65535));
      r.now_time  = gen_time + (48'($urandom_range(0, 12)) << 16);
      if ($urandom_range(15) == 0) r.msg_stamp = rand_stamp();
      if ($urandom_range(15) == 0) r.now_time = rand_stamp();
      if ($urandom_range(31) == 0) r.now_time = STAMP_MAX;
      if (r.kind == KIND_TAKE) gen_time += 48'($urandom_range(0, 2)) << 16;
      req_pending.insert(req_pending.size(), r);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (req_pending.size() != 0 || rsp_expected.size() != 0);
  endtask

  // Driver: offers the oldest pending request; predicts on each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        drv_req = req_pending[0];
        req_pending.delete(0);
        sorted_queue_step(drv_req, drv_rsp);
        rsp_expected.insert(rsp_expected.size(), drv_rsp);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (req_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid     <= 1'b1;
          in_ch.kind      <= req_pending[0].kind;
          in_ch.msg_tag   <= req_pending[0].msg_tag;
          in_ch.msg_stamp <= req_pending[0].msg_stamp;
          in_ch.now_time  <= req_pending[0].now_time;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (rsp_expected.size() == 0) begin
        report_mismatch("result with none expected", '0, '0);
      end else begin
        mon_want = rsp_expected[0];
        rsp_expected.delete(0);
        if (out_ch.out_tag !== mon_want.out_tag)
          report_mismatch("out_tag", 48'(out_ch.out_tag), 48'(mon_want.out_tag));
        if (out_ch.gave !== mon_want.gave)
          report_mismatch("gave", 48'(out_ch.gave), 48'(mon_want.gave));
        if (out_ch.more_ready !== mon_want.more_ready)
          report_mismatch("more_ready", 48'(out_ch.more_ready), 48'(mon_want.more_ready));
        if (out_ch.found !== mon_want.found)
          report_mismatch("found", 48'(out_ch.found), 48'(mon_want.found));
        if (out_ch.head_stamp !== mon_want.head_stamp)
          report_mismatch("head_stamp", out_ch.head_stamp, mon_want.head_stamp);
        if (out_ch.dropped !== mon_want.dropped)
          report_mismatch("dropped", 48'(out_ch.dropped), 48'(mon_want.dropped));
      end
    end
    out_ch.ready <= !out_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off while the sender keeps offering
  initial begin
    wait (phase_no == 1);
    @(negedge clk);
    out_hold = 1'b1;
    repeat (300) @(negedge clk);
    out_hold = 1'b0;
  end

  // Stimulus and end of run
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_INSERT;
    in_ch.msg_tag   = '0;
    in_ch.msg_stamp = '0;
    in_ch.now_time  = '0;
    out_ch.ready    = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty queue, unused kind, extremes, equal stamps, due / not due
    add_req(KIND_PEEK, 16'h1234, rand_stamp(), rand_stamp());
    add_req(KIND_TAKE, 16'h0, '0, STAMP_MAX);
    add_req(KIND_UNUSED, 16'hFFFF, STAMP_MAX, STAMP_MAX);
    add_req(KIND_INSERT, 16'hFFFF, STAMP_MAX, '0);
    add_req(KIND_INSERT, 16'h0000, '0, STAMP_MAX);
    add_req(KIND_INSERT, 16'h0001, '0, '0);
    add_req(KIND_PEEK, 16'h0, '0, '0);
    add_req(KIND_TAKE, 16'h0, '0, '0);
    add_req(KIND_TAKE, 16'h0, '0, '0);
    add_req(KIND_TAKE, 16'h0, '0, STAMP_MAX - 1);
    add_req(KIND_PEEK, 16'h0, '0, '0);
    add_req(KIND_TAKE, 16'h0, '0, STAMP_MAX);
    // fill with falling stamps in equal pairs, then one more is dropped
    for (int i = 0; i < QDEPTH; i++)
      add_req(KIND_INSERT, 16'h0100 + 16'(i), 48'((QDEPTH - 1 - i) / 2) << 16, '0);
    add_req(KIND_INSERT, 16'hBEEF, 48'h5_0000, '0);
    add_req(KIND_PEEK, 16'h0, '0, '0);
    wait_drained();

    // Random phases: pressure with no idling, sender idle, receiver stall, both
    phase_no = 1;
    add_random_reqs(255);
    wait_drained();

    phase_no = 2;
    send_idle_pct = 46;
    recv_stall_pct = 0;
    add_random_reqs(255);
    wait_drained();

    phase_no = 3;
    send_idle_pct = 0;
    recv_stall_pct = 46;
    add_random_reqs(255);
    wait_drained();

    phase_no = 4;
    send_idle_pct = 16;
    recv_stall_pct = 16;
    add_random_reqs(255);
    wait_drained();

    repeat (10) @(posedge clk);
    if (rsp_expected.size() != 0)
      report_mismatch("results never seen", 48'(rsp_expected.size()), '0);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/tsq_pkg.sv
sv/tsq_if.sv
sv/tsq_ctrl.sv
sv/tsq_datapath.sv
sv/timestamp_ordered_queue_top.sv
verif/testbench.sv
